// ===== rtl/core/rcaf_pkg.sv =====
package rcaf_pkg;

    localparam int NUM_STREAMS    = 2;
    localparam int SEL_W          = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int NUM_CELLS      = 5;
    localparam int STEP_W         = $clog2(2 * NUM_CELLS);
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 17;
    localparam int STATE_FRAC     = 16;
    localparam int STATE_W        = 34;
    localparam int DIFF_W         = STATE_W + 1;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    localparam logic [1:0] MODEL_PASS = 2'd0;
    localparam logic [1:0] MODEL_FULL = 2'd1;
    localparam logic [1:0] MODEL_LED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LED     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_seq_state;

    typedef struct packed {
        logic                diff_en;
        logic                upd_en;
        logic                active;
        logic [SEL_W-1:0]    sel;
        logic [COEF_W-1:0]   coef;
    } t_cell_ctrl;

    function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] c);
        return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

    // truncate toward zero, then saturate to a 16-bit sample
    function automatic logic [SAMPLE_W-1:0] to_sample(input logic [STATE_W-1:0] v);
        logic                       neg;
        logic [DIFF_W-1:0]          ext;
        logic [DIFF_W-1:0]          mag;
        logic [DIFF_W-STATE_FRAC-1:0] q;
        logic signed [DIFF_W-STATE_FRAC:0] r;
        neg = v[STATE_W-1];
        ext = {v[STATE_W-1], v};
        mag = neg ? (~ext + DIFF_W'(1)) : ext;
        q   = mag[DIFF_W-1:STATE_FRAC];
        r   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (r > $signed((DIFF_W-STATE_FRAC+1)'(32767))) begin
            return 16'h7FFF;
        end else if (r < -$signed((DIFF_W-STATE_FRAC+1)'(32768))) begin
            return 16'h8000;
        end else begin
            return r[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/rcaf_cell.sv =====
module rcaf_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rcaf_pkg::t_cell_ctrl                i_ctrl,
    input  logic [rcaf_pkg::STATE_W-1:0]        i_x,
    output logic [rcaf_pkg::STATE_W-1:0]        o_y
);

    localparam int PROD_W = rcaf_pkg::DIFF_W + rcaf_pkg::COEF_W + 1;

    logic [rcaf_pkg::STATE_W-1:0] r_state [rcaf_pkg::NUM_STREAMS];
    logic [rcaf_pkg::DIFF_W-1:0]  r_diff;
    logic [rcaf_pkg::DIFF_W-1:0]  n_diff;
    logic [rcaf_pkg::STATE_W-1:0] r_y;
    logic [rcaf_pkg::STATE_W-1:0] n_state;
    logic [rcaf_pkg::STATE_W-1:0] w_cur;
    logic signed [PROD_W-1:0]     w_prod;

    assign w_cur  = r_state[i_ctrl.sel];
    assign n_diff = {i_x[rcaf_pkg::STATE_W-1], i_x} - {w_cur[rcaf_pkg::STATE_W-1], w_cur};
    assign w_prod = $signed(r_diff) * $signed({1'b0, i_ctrl.coef});
    // arithmetic shift right by the coefficient fraction bits floors the step
    assign n_state = w_cur + w_prod[rcaf_pkg::COEF_FRAC_BITS +: rcaf_pkg::STATE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rcaf_pkg::NUM_STREAMS; i++) begin
                r_state[i] <= '0;
            end
        end else if (i_ctrl.upd_en && i_ctrl.active) begin
            r_state[i_ctrl.sel] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.diff_en) begin
            r_diff <= n_diff;
        end
        if (i_ctrl.upd_en) begin
            r_y <= i_ctrl.active ? n_state : i_x;
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/core/rc_cascade_audio_filter_top.sv =====
// Cascaded one-pole lowpass filter for 16-bit audio, two independent streams.
// Input channel: i_in_valid / o_in_ready carry one word (stream select and a
// signed sample). Output channel: o_out_valid / i_out_ready carry one word,
// the filtered sample, one per input word, in order.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high;
// only while the block is idle.
// The filter is a row of five stage cells; the word walks the row, each cell
// first forming the difference, then doing the multiply and accumulate. One
// word is processed at a time, so a new word is taken only after the last
// has left the row. The input side accepts a new word while a finished result
// still sits in the output register.
// If the receiver stalls, the finished word waits at the end of the row until
// the output register frees, and no further input is taken meanwhile.
// Reset (synchronous, active low) clears all stage state, empties the output,
// and sets pass-through mode, LED select off and all coefficients to one.
module rc_cascade_audio_filter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [0:0]                           i_stream_select,
    input  logic signed [rcaf_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rcaf_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                 i_cfg_we,
    input  logic [rcaf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rcaf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NC = rcaf_pkg::NUM_CELLS;

    rcaf_pkg::t_seq_state r_state;
    rcaf_pkg::t_seq_state n_state;

    logic [1:0]                      r_filter_model;
    logic                            r_led_enable;
    logic [rcaf_pkg::COEF_W-1:0]     r_coef_first;
    logic [rcaf_pkg::COEF_W-1:0]     r_coef_second;
    logic [rcaf_pkg::COEF_W-1:0]     r_coef_led;

    logic [rcaf_pkg::STEP_W-1:0]     r_step;
    logic [rcaf_pkg::SEL_W-1:0]      r_sel;
    logic [rcaf_pkg::STATE_W-1:0]    r_x;
    logic                            r_out_valid;
    logic [rcaf_pkg::SAMPLE_W-1:0]   r_sample_out;

    logic                            w_accept;
    logic                            w_running;
    logic                            w_load_out;
    logic [rcaf_pkg::STATE_W-1:0]    w_normal;
    logic [rcaf_pkg::STATE_W-1:0]    w_chosen;
    logic [rcaf_pkg::STATE_W-1:0]    w_cell_out [NC];
    rcaf_pkg::t_cell_ctrl            w_ctrl [NC];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_model <= rcaf_pkg::MODEL_PASS;
            r_led_enable   <= 1'b0;
            r_coef_first   <= rcaf_pkg::COEF_ONE;
            r_coef_second  <= rcaf_pkg::COEF_ONE;
            r_coef_led     <= rcaf_pkg::COEF_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcaf_pkg::REG_FILTER_MODEL: r_filter_model <= i_cfg_data[1:0];
                rcaf_pkg::REG_LED_ENABLE:   r_led_enable   <= i_cfg_data[0];
                rcaf_pkg::REG_COEF_FIRST:   r_coef_first   <= i_cfg_data;
                rcaf_pkg::REG_COEF_SECOND:  r_coef_second  <= i_cfg_data;
                rcaf_pkg::REG_COEF_LED:     r_coef_led     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcaf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rcaf_pkg::ST_RUN;
                end
            end
            rcaf_pkg::ST_RUN: begin
                if (r_step == rcaf_pkg::STEP_W'(2 * NC - 1)) begin
                    n_state = rcaf_pkg::ST_FINISH;
                end
            end
            rcaf_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = rcaf_pkg::ST_IDLE;
                end
            end
            default: n_state = rcaf_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_running  = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            rcaf_pkg::ST_IDLE:   o_in_ready = 1'b1;
            rcaf_pkg::ST_RUN:    w_running  = 1'b1;
            rcaf_pkg::ST_FINISH: w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcaf_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
            end else if (w_running) begin
                r_step <= r_step + rcaf_pkg::STEP_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sel <= rcaf_pkg::SEL_W'(i_stream_select);
            r_x   <= {{(rcaf_pkg::STATE_W - rcaf_pkg::SAMPLE_W - rcaf_pkg::STATE_FRAC)
                       {i_sample_in[rcaf_pkg::SAMPLE_W-1]}},
                      i_sample_in, {rcaf_pkg::STATE_FRAC{1'b0}}};
        end
        if (w_load_out) begin
            r_sample_out <= rcaf_pkg::to_sample(w_chosen);
        end
    end

    // row of stage cells
    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [rcaf_pkg::STATE_W-1:0] w_in;

        always_comb begin
            w_ctrl[k].diff_en = w_running && (r_step == rcaf_pkg::STEP_W'(2 * k));
            w_ctrl[k].upd_en  = w_running && (r_step == rcaf_pkg::STEP_W'(2 * k + 1));
            w_ctrl[k].sel     = r_sel;
            w_ctrl[k].coef    = rcaf_pkg::clamp_coef(r_coef_led);
            w_ctrl[k].active  = 1'b0;
            case (r_filter_model)
                rcaf_pkg::MODEL_FULL: begin
                    w_ctrl[k].active = 1'b1;
                    if (k == 0) begin
                        w_ctrl[k].coef = rcaf_pkg::clamp_coef(r_coef_first);
                    end else if (k == 1) begin
                        w_ctrl[k].coef = rcaf_pkg::clamp_coef(r_coef_second);
                    end
                end
                rcaf_pkg::MODEL_LED: w_ctrl[k].active = (k != 0) && (k != NC - 1);
                default: w_ctrl[k].active = 1'b0;
            endcase
        end

        if (k == 0) begin : g_first
            assign w_in = r_x;
        end else begin : g_next
            assign w_in = w_cell_out[k-1];
        end

        rcaf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[k]),
            .i_x     (w_in),
            .o_y     (w_cell_out[k])
        );
    end

    assign w_normal = (r_filter_model == rcaf_pkg::MODEL_FULL) ? w_cell_out[1] : r_x;
    assign w_chosen = r_led_enable ? w_cell_out[NC-1] : w_normal;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

// ===== tb/rcaf_sample_checker.sv =====
`timescale 1ns / 100ps

module rcaf_sample_checker
    import rcaf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [0:0]                 i_stream_select,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic [1:0]                 model_q;
    logic                       led_q;
    logic [COEF_W-1:0]          coef_first_q;
    logic [COEF_W-1:0]          coef_second_q;
    logic [COEF_W-1:0]          coef_led_q;
    longint                     stage_acc [NUM_STREAMS][NUM_CELLS];
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // s += floor(a * (x - s) / 2^frac), a limited to one
    function automatic longint lowpass_step(input longint s, input longint x,
                                            input logic [COEF_W-1:0] c);
        longint a;
        a = (c > COEF_ONE) ? longint'(COEF_ONE) : longint'(c);
        return s + ((a * (x - s)) >>> COEF_FRAC_BITS);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_pcm(input longint v);
        longint r;
        r = (v >= 0) ? (v >>> STATE_FRAC) : -((-v) >>> STATE_FRAC);
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return SAMPLE_W'(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_word(
        input int ch, input logic signed [SAMPLE_W-1:0] smp);
        longint x;
        longint normal_v;
        longint led_v;
        x = longint'(smp) * (longint'(1) << STATE_FRAC);
        case (model_q)
            MODEL_FULL: begin
                stage_acc[ch][0] = lowpass_step(stage_acc[ch][0], x, coef_first_q);
                stage_acc[ch][1] = lowpass_step(stage_acc[ch][1], stage_acc[ch][0],
                                                 coef_second_q);
                normal_v = stage_acc[ch][1];
                stage_acc[ch][2] = lowpass_step(stage_acc[ch][2], normal_v, coef_led_q);
                stage_acc[ch][3] = lowpass_step(stage_acc[ch][3], stage_acc[ch][2],
                                                 coef_led_q);
                stage_acc[ch][4] = lowpass_step(stage_acc[ch][4], stage_acc[ch][3],
                                                 coef_led_q);
                led_v = stage_acc[ch][4];
            end
            MODEL_LED: begin
                normal_v = x;
                stage_acc[ch][1] = lowpass_step(stage_acc[ch][1], x, coef_led_q);
                stage_acc[ch][2] = lowpass_step(stage_acc[ch][2], stage_acc[ch][1],
                                                 coef_led_q);
                stage_acc[ch][3] = lowpass_step(stage_acc[ch][3], stage_acc[ch][2],
                                                 coef_led_q);
                led_v = stage_acc[ch][3];
            end
            default: begin
                return smp;
            end
        endcase
        return to_pcm(led_q ? led_v : normal_v);
    endfunction

    always @(posedge i_clk) begin : track
        int                         ch;
        int                         k;
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            model_q       = MODEL_PASS;
            led_q         = 1'b0;
            coef_first_q  = COEF_ONE;
            coef_second_q = COEF_ONE;
            coef_led_q    = COEF_ONE;
            for (ch = 0; ch < NUM_STREAMS; ch++) begin
                for (k = 0; k < NUM_CELLS; k++) begin
                    stage_acc[ch][k] = 0;
                end
            end
            expected_samples.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: no word expected, actual %0d", i_sample_out);
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_sample_out !== want) begin
                        $error("sample_out: expected %0d, actual %0d", want, i_sample_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FILTER_MODEL: model_q       = i_cfg_data[1:0];
                    REG_LED_ENABLE:   led_q         = i_cfg_data[0];
                    REG_COEF_FIRST:   coef_first_q  = i_cfg_data[COEF_W-1:0];
                    REG_COEF_SECOND:  coef_second_q = i_cfg_data[COEF_W-1:0];
                    REG_COEF_LED:     coef_led_q    = i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                ch = int'(i_stream_select) % NUM_STREAMS;
                expected_samples.push_back(filter_word(ch, i_sample_in));
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rcaf_pkg::*;

    localparam logic [1:0] MODEL_UNDEF  = 2'd3;
    localparam int         RANDOM_WORDS = 950;
    localparam int         CYCLE_LIMIT  = 500000;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_in_valid      = 1'b0;
    logic [0:0]                 i_stream_select = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_in     = '0;
    logic                       i_out_ready     = 1'b0;
    logic                       i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx       = REG_FILTER_MODEL;
    logic [CFG_DATA_W-1:0]      i_cfg_data      = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;

    int fail_count;
    int results_pending;
    int cycle_count = 0;
    int ready_mode  = 0;
    int ready_span  = 0;

    rc_cascade_audio_filter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_stream_select (i_stream_select),
        .i_sample_in     (i_sample_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    rcaf_sample_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_stream_select (i_stream_select),
        .i_sample_in     (i_sample_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_sample_out    (o_sample_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // receiver: ready pattern changes style every so often
    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_span <= $urandom_range(10, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 1);
            2:       i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic push_word(input logic sel, input logic signed [SAMPLE_W-1:0] smp);
        logic took;
        i_in_valid      <= 1'b1;
        i_stream_select <= sel;
        i_sample_in     <= smp;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (results_pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_filter(input logic [1:0] model, input logic led,
                                  input logic [COEF_W-1:0] c_first,
                                  input logic [COEF_W-1:0] c_second,
                                  input logic [COEF_W-1:0] c_led);
        write_reg(REG_FILTER_MODEL, CFG_DATA_W'(model));
        write_reg(REG_LED_ENABLE, CFG_DATA_W'(led));
        write_reg(REG_COEF_FIRST, CFG_DATA_W'(c_first));
        write_reg(REG_COEF_SECOND, CFG_DATA_W'(c_second));
        write_reg(REG_COEF_LED, CFG_DATA_W'(c_led));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] pick_model();
        case ($urandom_range(0, 9))
            0:             return MODEL_PASS;
            1:             return MODEL_UNDEF;
            2, 3, 4, 5:    return MODEL_FULL;
            default:       return MODEL_LED;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return COEF_W'($urandom_range(65537, 131071));
            3:       return COEF_W'($urandom_range(1, 255));
            4:       return COEF_W'(65535);
            default: return COEF_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($signed($urandom_range(0, 32)) - 16);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int                         random_sent;
        int                         phase_len;
        int                         burst_len;
        int                         n;
        int                         k;
        logic                       hold;
        logic signed [SAMPLE_W-1:0] level;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every mode, undefined mode, coefficient zero and above one
        program_filter(MODEL_PASS, 1'b0, COEF_ONE, COEF_ONE, COEF_ONE);
        push_word(1'b0, 16'sh8000);
        push_word(1'b1, 16'sh7FFF);
        push_word(1'b0, 16'sh0000);
        push_word(1'b1, 16'shFFFF);
        drain_results();
        program_filter(MODEL_UNDEF, 1'b1, COEF_ONE, COEF_ONE, COEF_ONE);
        push_word(1'b0, 16'sd12345);
        push_word(1'b1, -16'sd20000);
        drain_results();
        program_filter(MODEL_FULL, 1'b1, COEF_ONE, COEF_ONE, COEF_ONE);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b1, 16'sh8000);
        push_word(1'b0, 16'sh8000);
        drain_results();
        program_filter(MODEL_FULL, 1'b0, 17'h1FFFF, 17'd40000, 17'd0);
        push_word(1'b1, 16'sh7FFF);
        push_word(1'b1, 16'sh7FFF);
        push_word(1'b0, -16'sd12345);
        drain_results();
        program_filter(MODEL_FULL, 1'b1, 17'd1, 17'd65535, 17'd30000);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b0, 16'sh7FFF);
        drain_results();
        program_filter(MODEL_LED, 1'b1, 17'd0, 17'd0, 17'h1FFFF);
        push_word(1'b0, 16'sh8000);
        push_word(1'b1, 16'sh0001);
        drain_results();
        program_filter(MODEL_LED, 1'b1, COEF_ONE, COEF_ONE, 17'd0);
        push_word(1'b0, 16'sh7FFF);
        drain_results();
        program_filter(MODEL_LED, 1'b0, COEF_ONE, COEF_ONE, 17'd9000);
        push_word(1'b1, 16'sh8000);
        push_word(1'b1, 16'sh7FFF);

        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            drain_results();
            program_filter(pick_model(), 1'($urandom_range(0, 1)),
                           pick_coef(), pick_coef(), pick_coef());
            phase_len = $urandom_range(30, 120);
            n = 0;
            while (n < phase_len) begin
                burst_len = $urandom_range(1, 16);
                hold      = ($urandom_range(0, 2) == 0);
                level     = pick_sample();
                for (k = 0; k < burst_len && n < phase_len; k++) begin
                    push_word(1'($urandom_range(0, 1)), hold ? level : pick_sample());
                    n++;
                end
                if ($urandom_range(0, 11) == 0) begin
                    drain_results();
                end else if ($urandom_range(0, 3) != 0) begin
                    idle_cycles($urandom_range(1, 8));
                end
            end
            random_sent += n;
        end

        drain_results();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== rc_cascade_audio_filter_top.f =====
rtl/core/rcaf_pkg.sv
rtl/core/rcaf_cell.sv
rtl/core/rc_cascade_audio_filter_top.sv
tb/rcaf_sample_checker.sv
tb/tb.sv
